### rtl/core/zrw_pkg.sv
// Shared types and constants for the zero-run word compressor.
package zrw_pkg;

  // Default word width and fixed port widths
  localparam int WORD_BITS_DEF  = 32;
  localparam int OUT_BITS       = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CMD_DEPTH      = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP   = CFG_INDEX_BITS'(1);

  // How the pending zero run is settled before a data word
  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_ONE,
    RUN_TWO,
    RUN_LONG
  } run_kind_t;

  localparam int KIND_BITS = 2;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

### rtl/core/zrw_front.sv
// Front end: counts zero runs and queues one command per nonzero word.
module zrw_front
  import zrw_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CMD_BITS  = KIND_BITS + 1 + 2 * WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  fifo_status_t         cmd_status,
  output logic                 in_full,
  output logic                 cmd_push,
  output logic [CMD_BITS-1:0]  cmd_data
);

  localparam logic [WORD_BITS-1:0] COUNT_MAX = '1;

  logic [WORD_BITS-1:0] count_r, count_nxt;
  logic                 clip_r, clip_nxt;
  logic                 accept;
  logic                 is_zero;
  run_kind_t            kind;

  // Accept while the command queue has room
  assign in_full = cmd_status.full;
  assign accept  = in_push && !cmd_status.full;
  assign is_zero = (in_data_word == '0);

  // Classify the pending run
  always_comb begin
    if (count_r == '0) begin
      kind = RUN_NONE;
    end else if (count_r == WORD_BITS'(1)) begin
      kind = RUN_ONE;
    end else if (count_r == WORD_BITS'(2)) begin
      kind = RUN_TWO;
    end else begin
      kind = RUN_LONG;
    end
  end

  // Queue a command on each nonzero word
  assign cmd_push = accept && !is_zero;
  assign cmd_data = {kind, clip_r, count_r, in_data_word};

  // Advance run counter, saturate and flag at maximum
  always_comb begin
    count_nxt = count_r;
    clip_nxt  = clip_r;
    if (accept) begin
      if (is_zero) begin
        if (count_r == COUNT_MAX) begin
          clip_nxt = 1'b1;
        end else begin
          count_nxt = count_r + WORD_BITS'(1);
        end
      end else begin
        count_nxt = '0;
        clip_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clip_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      clip_r  <= clip_nxt;
    end
  end

endmodule

### rtl/core/zrw_cmd_fifo.sv
// Short command queue between front and back end.
module zrw_cmd_fifo
  import zrw_pkg::*;
#(
  parameter int WIDTH = KIND_BITS + 1 + 2 * WORD_BITS_DEF,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_status_t     status
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign status.full  = (cnt_r == CNT_BITS'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr_r];

  // Advance pointers with wrap at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/zrw_back.sv
// Back end: expands each command into one to three output words.
module zrw_back
  import zrw_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CMD_BITS  = KIND_BITS + 1 + 2 * WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CMD_BITS-1:0]      cmd_data,
  input  fifo_status_t             cmd_status,
  output logic                     cmd_pop,
  input  logic [CFG_DATA_BITS-1:0] marker,
  input  logic                     swap,
  input  logic                     out_pop,
  output logic                     out_empty,
  output logic [OUT_BITS-1:0]      out_word,
  output logic                     out_last_of_run,
  output logic                     out_count_clipped
);

  localparam int NBYTES = WORD_BITS / 8;

  run_kind_t            kind;
  logic                 cmd_clip;
  logic [WORD_BITS-1:0] cmd_count;
  logic [WORD_BITS-1:0] cmd_word;
  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           last_phase;
  logic                 advance;
  logic                 is_last;
  logic [WORD_BITS-1:0] word_sel;
  logic                 clip_sel;
  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_word_r;
  logic                 out_last_r;
  logic                 out_clip_r;

  // Reverse the bytes of a word
  function automatic logic [WORD_BITS-1:0] swap_word(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < NBYTES; i++) begin
      r[8 * (NBYTES - 1 - i) +: 8] = w[8 * i +: 8];
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] ctl_word(input logic [WORD_BITS-1:0] w,
                                                    input logic sw);
    return sw ? swap_word(w) : w;
  endfunction

  // Unpack the command at the queue head
  assign kind      = run_kind_t'(cmd_data[CMD_BITS-1 -: KIND_BITS]);
  assign cmd_clip  = cmd_data[2 * WORD_BITS];
  assign cmd_count = cmd_data[2 * WORD_BITS - 1 -: WORD_BITS];
  assign cmd_word  = cmd_data[WORD_BITS-1:0];

  // Step when a command waits and the output slot is free or draining
  assign advance = !cmd_status.empty && (!out_valid_r || out_pop);

  always_comb begin
    unique case (kind)
      RUN_NONE: last_phase = 2'd0;
      RUN_ONE:  last_phase = 2'd1;
      RUN_TWO:  last_phase = 2'd2;
      RUN_LONG: last_phase = 2'd2;
      default:  last_phase = 2'd0;
    endcase
  end

  assign is_last = (phase_r == last_phase);
  assign cmd_pop = advance && is_last;

  // Select the word for this phase
  always_comb begin
    word_sel = cmd_word;
    clip_sel = 1'b0;
    if (!is_last) begin
      if (kind == RUN_LONG) begin
        if (phase_r == 2'd0) begin
          word_sel = ctl_word(WORD_BITS'(marker), swap);
        end else begin
          word_sel = ctl_word(cmd_count, swap);
          clip_sel = cmd_clip;
        end
      end else begin
        word_sel = '0;
      end
    end
  end

  assign phase_nxt = !advance ? phase_r : (is_last ? 2'd0 : phase_r + 2'd1);

  // Hold or load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= OUT_BITS'(word_sel);
      out_last_r <= is_last;
      out_clip_r <= clip_sel;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_word          = out_word_r;
  assign out_last_of_run   = out_last_r;
  assign out_count_clipped = out_clip_r;

endmodule

### rtl/core/zero_run_word_compressor.sv
// Top level of the zero-run word compressor: config registers, front, queue, back.
//
//   channel  direction  handshake            payload
//   in_      input      in_push / in_full    in_data_word
//   out_     output     out_pop / out_empty  out_word, out_last_of_run, out_count_clipped
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A zero word is accepted and emits nothing. A nonzero word emits one
// to three words, one per cycle through the single output register unless
// the output stalls. The first word passes through the queue entry, written
// at the accepting edge, and then the output register. The two-entry command
// queue lets input continue while the output drains or stalls; in_full rises
// when it fills. Reset is synchronous and clears counters, queue and output.
module zero_run_word_compressor
  import zrw_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [WORD_BITS-1:0]      in_data_word,
  output logic                      in_full,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [OUT_BITS-1:0]       out_word,
  output logic                      out_last_of_run,
  output logic                      out_count_clipped,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int CMD_BITS = KIND_BITS + 1 + 2 * WORD_BITS;

  logic [CFG_DATA_BITS-1:0] marker_r;
  logic                     swap_r;
  logic                     cmd_push;
  logic                     cmd_pop;
  logic [CMD_BITS-1:0]      cmd_wdata;
  logic [CMD_BITS-1:0]      cmd_rdata;
  fifo_status_t             cmd_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
      swap_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MARKER) begin
        marker_r <= cfg_wdata;
      end else if (cfg_index == REG_SWAP) begin
        swap_r <= cfg_wdata[0];
      end
    end
  end

  zrw_front #(
    .WORD_BITS (WORD_BITS),
    .CMD_BITS  (CMD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_word (in_data_word),
    .cmd_status   (cmd_status),
    .in_full      (in_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata)
  );

  zrw_cmd_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .pop       (cmd_pop),
    .pop_data  (cmd_rdata),
    .status    (cmd_status)
  );

  zrw_back #(
    .WORD_BITS (WORD_BITS),
    .CMD_BITS  (CMD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_data          (cmd_rdata),
    .cmd_status        (cmd_status),
    .cmd_pop           (cmd_pop),
    .marker            (marker_r),
    .swap              (swap_r),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_word          (out_word),
    .out_last_of_run   (out_last_of_run),
    .out_count_clipped (out_count_clipped)
  );

`ifndef SYNTHESIS
  // A queued command never overruns a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_status.full)
    else $error("command pushed into full queue");

  // A clipped count word is never the last word of a transaction
  a_clip_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_count_clipped) |-> !out_last_of_run)
    else $error("clip flag on final word");

  // Back end never pops an empty queue
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_status.empty)
    else $error("command popped from empty queue");

  // A waiting command with a free output slot shows a word next cycle
  a_output_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd_status.empty && out_empty) |=> !out_empty)
    else $error("output stayed empty with command waiting");
`endif

endmodule
